### sv/mid_pkg.sv
`timescale 1ns / 1ps

package mid_pkg;

    // Operand layout formats
    typedef enum logic [4:0] {
        FM_UNK   = 5'd0,
        FM_NONE  = 5'd1,
        FM_RRR   = 5'd2,
        FM_RR    = 5'd3,
        FM_SHIFT = 5'd4,
        FM_MOVCI = 5'd5,
        FM_JR    = 5'd6,
        FM_JALR  = 5'd7,
        FM_CODE  = 5'd8,
        FM_SYNC  = 5'd9,
        FM_RD    = 5'd10,
        FM_RS    = 5'd11,
        FM_TRAP  = 5'd12,
        FM_EXT   = 5'd13,
        FM_RTRD  = 5'd14,
        FM_RI    = 5'd15,
        FM_J     = 5'd16,
        FM_RRI   = 5'd17,
        FM_LUI   = 5'd18,
        FM_MEM   = 5'd19,
        FM_SYNCI = 5'd20
    } fmt_t;

    // One table leaf: mnemonic code and operand format.
    typedef struct packed {
        logic [6:0] code;
        fmt_t       fmt;
    } leaf_t;

    // Decode result carried from the operand extractor to the output register.
    typedef struct packed {
        logic [31:0] word;
        logic        known;
        logic [6:0]  code;
        logic        offset_form;
        logic [2:0]  count;
        logic [3:0]  kinds;
        logic [25:0] opa;
        logic [25:0] opb;
        logic [25:0] opc;
        logic [25:0] opd;
    } result_t;

    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_REGIMM   = 6'h01;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
    localparam logic [5:0] OP_SPECIAL3 = 6'h1F;
    localparam logic [5:0] FN_BSHFL    = 6'h20;

    localparam logic [1:0] REG_SWAP_BYTES = 2'd0;

    function automatic leaf_t mk(input int code, input fmt_t fmt);
        leaf_t l;
        l.code = 7'(code);
        l.fmt  = fmt;
        return l;
    endfunction

    function automatic leaf_t nop_leaf(input logic [4:0] sa);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (sa)
            5'd0: l = mk(0, FM_NONE);
            5'd1: l = mk(1, FM_NONE);
            5'd3: l = mk(2, FM_NONE);
            5'd4: l = mk(3, FM_RRR);
            5'd5: l = mk(4, FM_NONE);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t spc_leaf(input logic [5:0] fn);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (fn)
            6'h01: l = mk(6, FM_MOVCI);
            6'h02: l = mk(7, FM_SHIFT);
            6'h03: l = mk(8, FM_SHIFT);
            6'h04: l = mk(3, FM_RRR);
            6'h06: l = mk(9, FM_RRR);
            6'h07: l = mk(10, FM_RRR);
            6'h08: l = mk(11, FM_JR);
            6'h09: l = mk(12, FM_JALR);
            6'h0A: l = mk(13, FM_RRR);
            6'h0B: l = mk(14, FM_RRR);
            6'h0C: l = mk(15, FM_CODE);
            6'h0D: l = mk(23, FM_CODE);
            6'h0F: l = mk(16, FM_SYNC);
            6'h10: l = mk(17, FM_RD);
            6'h11: l = mk(18, FM_RS);
            6'h12: l = mk(19, FM_RD);
            6'h13: l = mk(20, FM_RS);
            6'h18: l = mk(21, FM_RR);
            6'h19: l = mk(22, FM_RR);
            6'h1A: l = mk(24, FM_RR);
            6'h1B: l = mk(25, FM_RR);
            6'h20: l = mk(26, FM_RRR);
            6'h21: l = mk(27, FM_RRR);
            6'h22: l = mk(28, FM_RRR);
            6'h23: l = mk(29, FM_RRR);
            6'h24: l = mk(30, FM_RRR);
            6'h25: l = mk(31, FM_RRR);
            6'h26: l = mk(32, FM_RRR);
            6'h27: l = mk(33, FM_RRR);
            6'h2A: l = mk(34, FM_RRR);
            6'h2B: l = mk(35, FM_RRR);
            6'h30: l = mk(36, FM_TRAP);
            6'h31: l = mk(37, FM_TRAP);
            6'h32: l = mk(38, FM_TRAP);
            6'h33: l = mk(39, FM_TRAP);
            6'h34: l = mk(40, FM_TRAP);
            6'h36: l = mk(41, FM_TRAP);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t spc2_leaf(input logic [5:0] fn);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (fn)
            6'h00: l = mk(42, FM_RR);
            6'h01: l = mk(43, FM_RR);
            6'h02: l = mk(44, FM_RRR);
            6'h04: l = mk(45, FM_RR);
            6'h05: l = mk(46, FM_RR);
            6'h20: l = mk(47, FM_RRR);
            6'h21: l = mk(48, FM_RRR);
            6'h3F: l = mk(49, FM_CODE);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t shfl_leaf(input logic [4:0] sa);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (sa)
            5'h02: l = mk(50, FM_RTRD);
            5'h10: l = mk(51, FM_RTRD);
            5'h18: l = mk(52, FM_RTRD);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t spc3_leaf(input logic [5:0] fn);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (fn)
            6'h00: l = mk(53, FM_EXT);
            6'h04: l = mk(54, FM_EXT);
            6'h3B: l = mk(55, FM_RTRD);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t rimm_leaf(input logic [4:0] rt);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (rt)
            5'h00: l = mk(56, FM_RI);
            5'h01: l = mk(57, FM_RI);
            5'h02: l = mk(58, FM_RI);
            5'h03: l = mk(59, FM_RI);
            5'h08: l = mk(60, FM_RI);
            5'h09: l = mk(61, FM_RI);
            5'h0A: l = mk(62, FM_RI);
            5'h0B: l = mk(63, FM_RI);
            5'h0C: l = mk(64, FM_RI);
            5'h0E: l = mk(65, FM_RI);
            5'h10: l = mk(66, FM_RI);
            5'h11: l = mk(67, FM_RI);
            5'h12: l = mk(68, FM_RI);
            5'h13: l = mk(69, FM_RI);
            5'h1F: l = mk(70, FM_SYNCI);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

    function automatic leaf_t prim_leaf(input logic [5:0] op);
        leaf_t l;
        l = mk(0, FM_UNK);
        unique case (op)
            6'h02: l = mk(71, FM_J);
            6'h03: l = mk(72, FM_J);
            6'h04: l = mk(73, FM_RRI);
            6'h05: l = mk(74, FM_RRI);
            6'h06: l = mk(75, FM_RI);
            6'h07: l = mk(76, FM_RI);
            6'h08: l = mk(77, FM_RRI);
            6'h09: l = mk(78, FM_RRI);
            6'h0A: l = mk(79, FM_RRI);
            6'h0B: l = mk(80, FM_RRI);
            6'h0C: l = mk(81, FM_RRI);
            6'h0D: l = mk(82, FM_RRI);
            6'h0E: l = mk(83, FM_RRI);
            6'h0F: l = mk(84, FM_LUI);
            6'h10: l = mk(85, FM_NONE);
            6'h11: l = mk(86, FM_NONE);
            6'h12: l = mk(87, FM_NONE);
            6'h13: l = mk(88, FM_NONE);
            6'h14: l = mk(89, FM_RRI);
            6'h15: l = mk(90, FM_RRI);
            6'h16: l = mk(91, FM_RI);
            6'h17: l = mk(92, FM_RI);
            6'h20: l = mk(93, FM_MEM);
            6'h21: l = mk(94, FM_MEM);
            6'h22: l = mk(95, FM_MEM);
            6'h23: l = mk(96, FM_MEM);
            6'h24: l = mk(97, FM_MEM);
            6'h25: l = mk(98, FM_MEM);
            6'h26: l = mk(99, FM_MEM);
            6'h28: l = mk(100, FM_MEM);
            6'h29: l = mk(101, FM_MEM);
            6'h2A: l = mk(102, FM_MEM);
            6'h2B: l = mk(103, FM_MEM);
            6'h2E: l = mk(104, FM_MEM);
            6'h2F: l = mk(105, FM_MEM);
            6'h30: l = mk(106, FM_MEM);
            6'h31: l = mk(107, FM_MEM);
            6'h32: l = mk(108, FM_MEM);
            6'h33: l = mk(109, FM_MEM);
            6'h35: l = mk(110, FM_MEM);
            6'h36: l = mk(111, FM_MEM);
            6'h38: l = mk(112, FM_MEM);
            6'h39: l = mk(113, FM_MEM);
            6'h3A: l = mk(114, FM_MEM);
            6'h3D: l = mk(115, FM_MEM);
            6'h3E: l = mk(116, FM_MEM);
            default: l = mk(0, FM_UNK);
        endcase
        return l;
    endfunction

endpackage

### sv/mid_classify.sv
`timescale 1ns / 1ps

// Walks the opcode tables for one word and returns the selected leaf.
module mid_classify (
    input  logic [31:0]   word,
    output mid_pkg::leaf_t leaf
);

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rt;
    logic [4:0] sa;

    assign op = word[31:26];
    assign fn = word[5:0];
    assign rt = word[20:16];
    assign sa = word[10:6];

    // Select the table by primary opcode, then by the sub-field.
    always_comb
    begin
        unique case (op)
            mid_pkg::OP_SPECIAL:
            begin
                if (fn == 6'd0)
                    leaf = (rt != 5'd0) ? mid_pkg::mk(5, mid_pkg::FM_SHIFT)
                                        : mid_pkg::nop_leaf(sa);
                else
                    leaf = mid_pkg::spc_leaf(fn);
            end
            mid_pkg::OP_REGIMM:   leaf = mid_pkg::rimm_leaf(rt);
            mid_pkg::OP_SPECIAL2: leaf = mid_pkg::spc2_leaf(fn);
            mid_pkg::OP_SPECIAL3:
            begin
                if (fn == mid_pkg::FN_BSHFL)
                    leaf = mid_pkg::shfl_leaf(sa);
                else
                    leaf = mid_pkg::spc3_leaf(fn);
            end
            default:              leaf = mid_pkg::prim_leaf(op);
        endcase
    end

endmodule

### sv/mid_operands.sv
`timescale 1ns / 1ps

// Extracts the displayed operand fields for the leaf's format.
module mid_operands (
    input  logic [31:0]     word,
    input  mid_pkg::leaf_t  leaf,
    output mid_pkg::result_t res
);

    logic [25:0] rs_f;
    logic [25:0] rt_f;
    logic [25:0] rd_f;
    logic [25:0] sa_f;
    logic [25:0] imm_f;

    assign rs_f  = {21'd0, word[25:21]};
    assign rt_f  = {21'd0, word[20:16]};
    assign rd_f  = {21'd0, word[15:11]};
    assign sa_f  = {21'd0, word[10:6]};
    assign imm_f = {10'd0, word[15:0]};

    always_comb
    begin
        res             = '0;
        res.word        = word;
        res.known       = (leaf.fmt != mid_pkg::FM_UNK);
        res.code        = res.known ? leaf.code : 7'd0;
        res.offset_form = (leaf.fmt == mid_pkg::FM_MEM) || (leaf.fmt == mid_pkg::FM_SYNCI);
        unique case (leaf.fmt)
            mid_pkg::FM_RRR:
            begin
                res.count = 3'd3; res.kinds = 4'd7;
                res.opa = rs_f; res.opb = rt_f; res.opc = rd_f;
            end
            mid_pkg::FM_RR:
            begin
                res.count = 3'd2; res.kinds = 4'd3;
                res.opa = rs_f; res.opb = rt_f;
            end
            mid_pkg::FM_SHIFT:
            begin
                res.count = 3'd3; res.kinds = 4'd3;
                res.opa = rt_f; res.opb = rd_f; res.opc = sa_f;
            end
            mid_pkg::FM_MOVCI:
            begin
                res.count = 3'd4; res.kinds = 4'd9;
                res.opa = rs_f; res.opb = {23'd0, word[20:18]};
                res.opc = {25'd0, word[16]}; res.opd = rd_f;
            end
            mid_pkg::FM_JR:
            begin
                res.count = 3'd2; res.kinds = 4'd1;
                res.opa = rs_f; res.opb = sa_f;
            end
            mid_pkg::FM_JALR:
            begin
                res.count = 3'd3; res.kinds = 4'd3;
                res.opa = rs_f; res.opb = rd_f; res.opc = sa_f;
            end
            mid_pkg::FM_CODE:
            begin
                res.count = 3'd1; res.opa = {6'd0, word[25:6]};
            end
            mid_pkg::FM_SYNC:
            begin
                res.count = 3'd1; res.opa = sa_f;
            end
            mid_pkg::FM_RD:
            begin
                res.count = 3'd1; res.kinds = 4'd1; res.opa = rd_f;
            end
            mid_pkg::FM_RS:
            begin
                res.count = 3'd1; res.kinds = 4'd1; res.opa = rs_f;
            end
            mid_pkg::FM_TRAP:
            begin
                res.count = 3'd3; res.kinds = 4'd3;
                res.opa = rs_f; res.opb = rt_f; res.opc = {16'd0, word[15:6]};
            end
            mid_pkg::FM_EXT:
            begin
                res.count = 3'd4; res.kinds = 4'd3;
                res.opa = rs_f; res.opb = rt_f; res.opc = rd_f; res.opd = sa_f;
            end
            mid_pkg::FM_RTRD:
            begin
                res.count = 3'd2; res.kinds = 4'd3;
                res.opa = rt_f; res.opb = rd_f;
            end
            mid_pkg::FM_RI:
            begin
                res.count = 3'd2; res.kinds = 4'd1;
                res.opa = rs_f; res.opb = imm_f;
            end
            mid_pkg::FM_J:
            begin
                res.count = 3'd1; res.opa = word[25:0];
            end
            mid_pkg::FM_RRI:
            begin
                res.count = 3'd3; res.kinds = 4'd3;
                res.opa = rs_f; res.opb = rt_f; res.opc = imm_f;
            end
            mid_pkg::FM_LUI:
            begin
                res.count = 3'd2; res.kinds = 4'd1;
                res.opa = rt_f; res.opb = imm_f;
            end
            mid_pkg::FM_MEM:
            begin
                res.count = 3'd3; res.kinds = 4'd4;
                res.opa = rt_f; res.opb = imm_f; res.opc = rs_f;
            end
            mid_pkg::FM_SYNCI:
            begin
                res.count = 3'd3; res.kinds = 4'd5;
                res.opa = rt_f; res.opb = imm_f; res.opc = rs_f;
            end
            default:
            begin
                res.count = 3'd0;
            end
        endcase
    end

endmodule

### sv/mips32_instruction_decoder.sv
`timescale 1ns / 1ps
// Pipeline: the input item is held in the input register, then its decode is held in
// the result register. Throughput: one item per cycle while the receiver takes
// results; the result register is refilled whenever it is empty or being taken in
// the same cycle.
// Reset (rst_n low, asynchronous) empties both registers and clears swap_bytes.
module mips32_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        valid,
    output logic        ready,
    input  logic [31:0] instruction_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] decoded_word,
    output logic        known,
    output logic [6:0]  mnemonic_code,
    output logic        offset_form,
    output logic [2:0]  operand_count,
    output logic [3:0]  kind_mask,
    output logic [25:0] operand_a,
    output logic [25:0] operand_b,
    output logic [25:0] operand_c,
    output logic [25:0] operand_d
);

    logic             swap_reg;
    logic             in_valid_reg;
    logic [31:0]      in_word_reg;
    logic             out_valid_reg;
    mid_pkg::result_t res_reg;
    logic [31:0]      word_sw;
    mid_pkg::leaf_t   leaf;
    mid_pkg::result_t res_next;
    logic             adv;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == mid_pkg::REG_SWAP_BYTES) ? {31'd0, swap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swap_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == mid_pkg::REG_SWAP_BYTES)
            swap_reg <= pwdata[0];
    end

    // Pipeline flow: stage 2 loads when empty or drained.
    assign adv   = !out_valid_reg || out_ready;
    assign ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready)
                in_valid_reg <= valid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
            in_word_reg <= instruction_word;
        if (adv && in_valid_reg)
            res_reg <= res_next;
    end

    // Optional byte swap ahead of decode
    assign word_sw = swap_reg ? {in_word_reg[7:0], in_word_reg[15:8],
                                 in_word_reg[23:16], in_word_reg[31:24]}
                              : in_word_reg;

    mid_classify u_classify (
        .word (word_sw),
        .leaf (leaf)
    );

    mid_operands u_operands (
        .word (word_sw),
        .leaf (leaf),
        .res  (res_next)
    );

    assign out_valid     = out_valid_reg;
    assign decoded_word  = res_reg.word;
    assign known         = res_reg.known;
    assign mnemonic_code = res_reg.code;
    assign offset_form   = res_reg.offset_form;
    assign operand_count = res_reg.count;
    assign kind_mask     = res_reg.kinds;
    assign operand_a     = res_reg.opa;
    assign operand_b     = res_reg.opb;
    assign operand_c     = res_reg.opc;
    assign operand_d     = res_reg.opd;

endmodule

### tb/sv/mips32_instruction_decoder_checker.sv
`timescale 1ns / 1ps

module mips32_instruction_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        swap_cfg,
    input  logic        valid,
    input  logic        ready,
    input  logic [31:0] instruction_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] decoded_word,
    input  logic        known,
    input  logic [6:0]  mnemonic_code,
    input  logic        offset_form,
    input  logic [2:0]  operand_count,
    input  logic [3:0]  kind_mask,
    input  logic [25:0] operand_a,
    input  logic [25:0] operand_b,
    input  logic [25:0] operand_c,
    input  logic [25:0] operand_d,
    output int          error_count,
    output int          pending_count
);

    typedef struct {
        logic [4:0] n;
        logic [3:0] kinds;
        int         pos[4];
        int         len[4];
    } layout_t;

    mid_pkg::result_t decode_queue[$];

    // Operand layout for each format.
    function automatic layout_t layout_of(input mid_pkg::fmt_t f);
        layout_t s;
        s.n = 0;
        s.kinds = 0;
        s.pos = '{0, 0, 0, 0};
        s.len = '{0, 0, 0, 0};
        case (f)
            mid_pkg::FM_RRR:   begin s.n = 3; s.kinds = 7; s.pos = '{21, 16, 11, 0};
                                     s.len = '{5, 5, 5, 0}; end
            mid_pkg::FM_RR:    begin s.n = 2; s.kinds = 3; s.pos = '{21, 16, 0, 0};
                                     s.len = '{5, 5, 0, 0}; end
            mid_pkg::FM_SHIFT: begin s.n = 3; s.kinds = 3; s.pos = '{16, 11, 6, 0};
                                     s.len = '{5, 5, 5, 0}; end
            mid_pkg::FM_MOVCI: begin s.n = 4; s.kinds = 9; s.pos = '{21, 18, 16, 11};
                                     s.len = '{5, 3, 1, 5}; end
            mid_pkg::FM_JR:    begin s.n = 2; s.kinds = 1; s.pos = '{21, 6, 0, 0};
                                     s.len = '{5, 5, 0, 0}; end
            mid_pkg::FM_JALR:  begin s.n = 3; s.kinds = 3; s.pos = '{21, 11, 6, 0};
                                     s.len = '{5, 5, 5, 0}; end
            mid_pkg::FM_CODE:  begin s.n = 1; s.pos = '{6, 0, 0, 0};
                                     s.len = '{20, 0, 0, 0}; end
            mid_pkg::FM_SYNC:  begin s.n = 1; s.pos = '{6, 0, 0, 0};
                                     s.len = '{5, 0, 0, 0}; end
            mid_pkg::FM_RD:    begin s.n = 1; s.kinds = 1; s.pos = '{11, 0, 0, 0};
                                     s.len = '{5, 0, 0, 0}; end
            mid_pkg::FM_RS:    begin s.n = 1; s.kinds = 1; s.pos = '{21, 0, 0, 0};
                                     s.len = '{5, 0, 0, 0}; end
            mid_pkg::FM_TRAP:  begin s.n = 3; s.kinds = 3; s.pos = '{21, 16, 6, 0};
                                     s.len = '{5, 5, 10, 0}; end
            mid_pkg::FM_EXT:   begin s.n = 4; s.kinds = 3; s.pos = '{21, 16, 11, 6};
                                     s.len = '{5, 5, 5, 5}; end
            mid_pkg::FM_RTRD:  begin s.n = 2; s.kinds = 3; s.pos = '{16, 11, 0, 0};
                                     s.len = '{5, 5, 0, 0}; end
            mid_pkg::FM_RI:    begin s.n = 2; s.kinds = 1; s.pos = '{21, 0, 0, 0};
                                     s.len = '{5, 16, 0, 0}; end
            mid_pkg::FM_J:     begin s.n = 1; s.len = '{26, 0, 0, 0}; end
            mid_pkg::FM_RRI:   begin s.n = 3; s.kinds = 3; s.pos = '{21, 16, 0, 0};
                                     s.len = '{5, 5, 16, 0}; end
            mid_pkg::FM_LUI:   begin s.n = 2; s.kinds = 1; s.pos = '{16, 0, 0, 0};
                                     s.len = '{5, 16, 0, 0}; end
            mid_pkg::FM_MEM:   begin s.n = 3; s.kinds = 4; s.pos = '{16, 0, 21, 0};
                                     s.len = '{5, 16, 5, 0}; end
            mid_pkg::FM_SYNCI: begin s.n = 3; s.kinds = 5; s.pos = '{16, 0, 21, 0};
                                     s.len = '{5, 16, 5, 0}; end
            default:  ;
        endcase
        return s;
    endfunction

    // Mnemonic and format lookup; tables are written out independently here.
    function automatic void classify_word(input logic [31:0] w, output int code,
                                          output mid_pkg::fmt_t f);
        logic [5:0] op;
        logic [5:0] fn;
        logic [4:0] rt;
        logic [4:0] sa;
        int         p;
        op = w[31:26];
        fn = w[5:0];
        rt = w[20:16];
        sa = w[10:6];
        code = 0;
        f = mid_pkg::FM_UNK;
        if (op == mid_pkg::OP_SPECIAL) begin
            if (fn == 0 && rt == 0) begin
                case (sa)
                    5'd0: begin code = 0; f = mid_pkg::FM_NONE; end
                    5'd1: begin code = 1; f = mid_pkg::FM_NONE; end
                    5'd3: begin code = 2; f = mid_pkg::FM_NONE; end
                    5'd4: begin code = 3; f = mid_pkg::FM_RRR; end
                    5'd5: begin code = 4; f = mid_pkg::FM_NONE; end
                    default: ;
                endcase
            end else if (fn == 0) begin
                code = 5; f = mid_pkg::FM_SHIFT;
            end else begin
                case (fn)
                    6'h01: begin code = 6; f = mid_pkg::FM_MOVCI; end
                    6'h02: begin code = 7; f = mid_pkg::FM_SHIFT; end
                    6'h03: begin code = 8; f = mid_pkg::FM_SHIFT; end
                    6'h04: begin code = 3; f = mid_pkg::FM_RRR; end
                    6'h06: begin code = 9; f = mid_pkg::FM_RRR; end
                    6'h07: begin code = 10; f = mid_pkg::FM_RRR; end
                    6'h08: begin code = 11; f = mid_pkg::FM_JR; end
                    6'h09: begin code = 12; f = mid_pkg::FM_JALR; end
                    6'h0A: begin code = 13; f = mid_pkg::FM_RRR; end
                    6'h0B: begin code = 14; f = mid_pkg::FM_RRR; end
                    6'h0C: begin code = 15; f = mid_pkg::FM_CODE; end
                    6'h0D: begin code = 23; f = mid_pkg::FM_CODE; end
                    6'h0F: begin code = 16; f = mid_pkg::FM_SYNC; end
                    6'h10: begin code = 17; f = mid_pkg::FM_RD; end
                    6'h11: begin code = 18; f = mid_pkg::FM_RS; end
                    6'h12: begin code = 19; f = mid_pkg::FM_RD; end
                    6'h13: begin code = 20; f = mid_pkg::FM_RS; end
                    6'h18: begin code = 21; f = mid_pkg::FM_RR; end
                    6'h19: begin code = 22; f = mid_pkg::FM_RR; end
                    6'h1A: begin code = 24; f = mid_pkg::FM_RR; end
                    6'h1B: begin code = 25; f = mid_pkg::FM_RR; end
                    6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27:
                        begin code = 26 + int'(fn - 6'h20); f = mid_pkg::FM_RRR; end
                    6'h2A: begin code = 34; f = mid_pkg::FM_RRR; end
                    6'h2B: begin code = 35; f = mid_pkg::FM_RRR; end
                    6'h30, 6'h31, 6'h32, 6'h33, 6'h34:
                        begin code = 36 + int'(fn - 6'h30); f = mid_pkg::FM_TRAP; end
                    6'h36: begin code = 41; f = mid_pkg::FM_TRAP; end
                    default: ;
                endcase
            end
        end else if (op == mid_pkg::OP_REGIMM) begin
            case (rt)
                5'h00, 5'h01, 5'h02, 5'h03:
                    begin code = 56 + int'(rt); f = mid_pkg::FM_RI; end
                5'h08, 5'h09, 5'h0A, 5'h0B, 5'h0C:
                    begin code = 60 + int'(rt - 5'h08); f = mid_pkg::FM_RI; end
                5'h0E: begin code = 65; f = mid_pkg::FM_RI; end
                5'h10, 5'h11, 5'h12, 5'h13:
                    begin code = 66 + int'(rt - 5'h10); f = mid_pkg::FM_RI; end
                5'h1F: begin code = 70; f = mid_pkg::FM_SYNCI; end
                default: ;
            endcase
        end else if (op == mid_pkg::OP_SPECIAL2) begin
            case (fn)
                6'h00: begin code = 42; f = mid_pkg::FM_RR; end
                6'h01: begin code = 43; f = mid_pkg::FM_RR; end
                6'h02: begin code = 44; f = mid_pkg::FM_RRR; end
                6'h04: begin code = 45; f = mid_pkg::FM_RR; end
                6'h05: begin code = 46; f = mid_pkg::FM_RR; end
                6'h20: begin code = 47; f = mid_pkg::FM_RRR; end
                6'h21: begin code = 48; f = mid_pkg::FM_RRR; end
                6'h3F: begin code = 49; f = mid_pkg::FM_CODE; end
                default: ;
            endcase
        end else if (op == mid_pkg::OP_SPECIAL3) begin
            if (fn == mid_pkg::FN_BSHFL) begin
                case (sa)
                    5'h02: begin code = 50; f = mid_pkg::FM_RTRD; end
                    5'h10: begin code = 51; f = mid_pkg::FM_RTRD; end
                    5'h18: begin code = 52; f = mid_pkg::FM_RTRD; end
                    default: ;
                endcase
            end else begin
                case (fn)
                    6'h00: begin code = 53; f = mid_pkg::FM_EXT; end
                    6'h04: begin code = 54; f = mid_pkg::FM_EXT; end
                    6'h3B: begin code = 55; f = mid_pkg::FM_RTRD; end
                    default: ;
                endcase
            end
        end else begin
            // Primary opcodes: sequential ranges with gaps.
            p = int'(op);
            if (p == 2 || p == 3) begin code = 69 + p; f = mid_pkg::FM_J; end
            else if (p == 4 || p == 5) begin code = 69 + p; f = mid_pkg::FM_RRI; end
            else if (p == 6 || p == 7) begin code = 69 + p; f = mid_pkg::FM_RI; end
            else if (p >= 8 && p <= 14) begin code = 69 + p; f = mid_pkg::FM_RRI; end
            else if (p == 15) begin code = 84; f = mid_pkg::FM_LUI; end
            else if (p >= 16 && p <= 19) begin code = 69 + p; f = mid_pkg::FM_NONE; end
            else if (p == 20 || p == 21) begin code = 69 + p; f = mid_pkg::FM_RRI; end
            else if (p == 22 || p == 23) begin code = 69 + p; f = mid_pkg::FM_RI; end
            else if (p >= 32 && p <= 38) begin code = 61 + p; f = mid_pkg::FM_MEM; end
            else if (p >= 40 && p <= 43) begin code = 60 + p; f = mid_pkg::FM_MEM; end
            else if (p == 46 || p == 47) begin code = 58 + p; f = mid_pkg::FM_MEM; end
            else if (p >= 48 && p <= 51) begin code = 58 + p; f = mid_pkg::FM_MEM; end
            else if (p == 53 || p == 54) begin code = 57 + p; f = mid_pkg::FM_MEM; end
            else if (p >= 56 && p <= 58) begin code = 56 + p; f = mid_pkg::FM_MEM; end
            else if (p == 61 || p == 62) begin code = 54 + p; f = mid_pkg::FM_MEM; end
        end
    endfunction

    // Expected decode of one fetched word under the current swap setting.
    function automatic mid_pkg::result_t predict_decode(input logic [31:0] raw,
                                                        input logic swap);
        mid_pkg::result_t r;
        logic [31:0]      w;
        int               code;
        mid_pkg::fmt_t    f;
        layout_t          s;
        logic [25:0]      vals[4];
        w = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
        classify_word(w, code, f);
        s = layout_of(f);
        for (int i = 0; i < 4; i++)
            vals[i] = (i < s.n) ? 26'((w >> s.pos[i]) & ((32'd1 << s.len[i]) - 1)) : '0;
        r.word = w;
        r.known = (f != mid_pkg::FM_UNK);
        r.code = (f != mid_pkg::FM_UNK) ? 7'(code) : 7'd0;
        r.offset_form = (f == mid_pkg::FM_MEM || f == mid_pkg::FM_SYNCI);
        r.count = 3'(s.n);
        r.kinds = s.kinds;
        r.opa = vals[0];
        r.opb = vals[1];
        r.opc = vals[2];
        r.opd = vals[3];
        return r;
    endfunction

    assign pending_count = decode_queue.size();

    // Record expectations on input acceptance and compare on output acceptance.
    always @(posedge clk) begin
        mid_pkg::result_t exp_r;
        mid_pkg::result_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{decoded_word, known, mnemonic_code, offset_form, operand_count,
                        kind_mask, operand_a, operand_b, operand_c, operand_d};
                if (decode_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected decode result: %p", got);
                end else begin
                    exp_r = decode_queue.pop_front();
                    if (got !== exp_r) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("decode mismatch\n  expected %p\n  actual   %p",
                                     exp_r, got);
                    end
                end
            end
            if (valid && ready)
                decode_queue.push_back(predict_decode(instruction_word, swap_cfg));
        end
    end

    initial error_count = 0;

endmodule

### tb/sv/mips32_instruction_decoder_tb.sv
`timescale 1ns / 1ps

module mips32_instruction_decoder_tb;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        valid = 0;
    logic        ready;
    logic [31:0] instruction_word = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] decoded_word;
    logic        known;
    logic [6:0]  mnemonic_code;
    logic        offset_form;
    logic [2:0]  operand_count;
    logic [3:0]  kind_mask;
    logic [25:0] operand_a;
    logic [25:0] operand_b;
    logic [25:0] operand_c;
    logic [25:0] operand_d;
    logic        swap_setting = 0;
    logic        hold_off = 0;
    int          error_count;
    int          pending_count;

    always #4 clk = ~clk;

    mips32_instruction_decoder DUT (.*);

    mips32_instruction_decoder_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .swap_cfg(swap_setting), .valid(valid), .ready(ready),
        .instruction_word(instruction_word), .out_valid(out_valid), .out_ready(out_ready),
        .decoded_word(decoded_word), .known(known), .mnemonic_code(mnemonic_code),
        .offset_form(offset_form), .operand_count(operand_count), .kind_mask(kind_mask),
        .operand_a(operand_a), .operand_b(operand_b), .operand_c(operand_c),
        .operand_d(operand_d), .error_count(error_count), .pending_count(pending_count)
    );

    // Write the swap register through a setup and an access cycle.
    task automatic write_swap(input logic value);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= mid_pkg::REG_SWAP_BYTES; pwdata <= {31'd0, value};
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        swap_setting <= value;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one word and hold it until the decoder takes it.
    task automatic send_word(input logic [31:0] w);
        instruction_word <= w;
        valid <= 1;
        @(posedge clk);
        while (!ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        valid <= 0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed words: pick a decodable opcode group and randomize the rest.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int          sel;
        w = $urandom;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: w[31:26] = mid_pkg::OP_SPECIAL;
            2: begin w[31:26] = mid_pkg::OP_SPECIAL; w[5:0] = 0;
                     if ($urandom_range(0, 1)) w[20:16] = 0;
                     w[10:6] = 5'($urandom_range(0, 7)); end
            3: w[31:26] = mid_pkg::OP_REGIMM;
            4: w[31:26] = mid_pkg::OP_SPECIAL2;
            5: begin w[31:26] = mid_pkg::OP_SPECIAL3;
                     if ($urandom_range(0, 1)) w[5:0] = mid_pkg::FN_BSHFL; end
            default: ;
        endcase
        return w;
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge clk);
            phase++;
            if (hold_off) out_ready <= 0;
            else if (phase % 300 < 60) out_ready <= 1;
            else out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [31:0] directed[$];
        int          gap;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        repeat (2) @(negedge clk);

        // Field extremes and each table's special rows.
        directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0040, 32'h0000_00C0,
                     32'h0000_0100, 32'h0000_0140, 32'h0000_0080, 32'h0000_0180,
                     32'h0001_0000, 32'h0000_FFC0, 32'h03FF_FFC1, 32'h0000_000F,
                     32'h7C00_0020 | (5'h02 << 6), 32'h7C00_0020 | (5'h10 << 6),
                     32'h7C00_0020 | (5'h18 << 6), 32'h7C00_0020 | (5'h03 << 6),
                     32'h7FFF_FFFB, 32'h041F_FFFF, 32'h0414_0000, 32'h5800_1234,
                     32'h5C00_FFFF, 32'h8C00_8000, 32'hBC00_0000, 32'h0BFF_FFFF,
                     32'h7000_003F};
        foreach (directed[i]) send_word(directed[i]);
        wait_drained();

        // Every primary opcode once, unswapped then swapped.
        for (int s = 0; s < 2; s++) begin
            write_swap(s[0]);
            for (int op = 0; op < 64; op++)
                send_word({6'(op), 26'($urandom)});
            wait_drained();
        end
        write_swap(0);

        // Random traffic in bursts; a long receiver hold-off midway.
        for (int n = 0; n < 1300; n++) begin
            if (n == 400) begin
                hold_off <= 1;
                fork
                    begin repeat (80) @(negedge clk); hold_off <= 0; end
                join_none
            end
            if (n == 650 || n == 1000) begin
                wait_drained();
                write_swap(n == 650);
            end
            send_word(pick_word());
            if ($urandom_range(0, 7) == 0) begin
                drop_valid();
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
        end
        wait_drained();
        repeat (10) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
sv/mid_pkg.sv
sv/mid_classify.sv
sv/mid_operands.sv
sv/mips32_instruction_decoder.sv
tb/sv/mips32_instruction_decoder_checker.sv
tb/sv/mips32_instruction_decoder_tb.sv
